>>> sv/packet_block_interleaver_defines.svh
// Assertion macros for the packet block interleaver.
// Self-contained; taken in by the top level.
`ifndef PACKET_BLOCK_INTERLEAVER_DEFINES_SVH
`define PACKET_BLOCK_INTERLEAVER_DEFINES_SVH

// same-cycle implication
`define PBI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pbi: same-cycle check failed");

// next-cycle implication
`define PBI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pbi: next-cycle check failed");

`endif

>>> sv/pbi_pkg.sv
// Shared types and constants for the packet block interleaver.
// No dependencies.
`default_nettype none

package pbi_pkg;

	localparam int SIZE_W    = 5;
	localparam int ORDER_W   = 64;
	localparam int ENTRY_W   = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SEND_ORDER = 1'b1;

	localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RST = 5'd16;
	localparam logic [ORDER_W-1:0] SEND_ORDER_RST = 64'hFEDC_BA98_7654_3210;

	typedef struct packed {
		logic store;      // write request handle into slot at put pointer
		logic clr_ptrs;   // flush request: both pointers to zero
		logic read_hit;   // read slot named at send pointer, clear it, advance
		logic read_flush; // read lowest occupied slot, clear it
		logic load;       // load output register from read data
		logic last;
	} cmd_t;

	typedef struct packed {
		logic hit;        // slot at send pointer in block and occupied
		logic occ_any;
		logic out_free;
		logic ptrs_zero;
	} stat_t;

endpackage

`default_nettype wire

>>> sv/pbi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module pbi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  wr_en,
	input  wire logic [AW-1:0]         wr_addr,
	input  wire logic [WIDTH-1:0]      wr_data,
	input  wire logic                  rd_en,
	input  wire logic [AW-1:0]         rd_addr,
	output logic      [WIDTH-1:0]      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> sv/pbi_ctrl.sv
// Sequencer for the packet block interleaver.
// Depends on pbi_pkg.
`default_nettype none

module pbi_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          mode,
	output logic               in_stall,
	input  wire pbi_pkg::stat_t stat,
	output pbi_pkg::cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_FSCAN = 4'b0100,
		ST_LOAD  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   flush_q, flush_d;
	logic   last_c;

	assign in_stall = (state_q != ST_IDLE);
	assign last_c   = flush_q ? !stat.occ_any : !stat.hit;

	always_comb begin
		state_d = state_q;
		flush_d = flush_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (mode) begin
						cmd.clr_ptrs = 1'b1;
						flush_d      = 1'b1;
						state_d      = ST_FSCAN;
					end else begin
						cmd.store = 1'b1;
						flush_d   = 1'b0;
						state_d   = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (stat.hit) begin
					cmd.read_hit = 1'b1;
					state_d      = ST_LOAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FSCAN: begin
				if (stat.occ_any) begin
					cmd.read_flush = 1'b1;
					state_d        = ST_LOAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_LOAD: begin
				if (stat.out_free) begin
					cmd.load = 1'b1;
					cmd.last = last_c;
					if (last_c) begin
						state_d = ST_IDLE;
					end else if (flush_q) begin
						state_d = ST_FSCAN;
					end else begin
						state_d = ST_CHECK;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			flush_q <= 1'b0;
		end else begin
			state_q <= state_d;
			flush_q <= flush_d;
		end
	end

endmodule

`default_nettype wire

>>> sv/pbi_datapath.sv
// Slot store, occupancy, pointers, config registers and output register.
// Depends on pbi_pkg and pbi_ram.
`default_nettype none

module pbi_datapath #(
	parameter int MAX_BLOCK    = 16,
	parameter int HANDLE_WIDTH = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	input  wire logic [pbi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pbi_pkg::ORDER_W-1:0]      cfg_data,
	input  wire logic [HANDLE_WIDTH-1:0]          packet_handle,
	input  wire logic                             out_stall,
	input  wire pbi_pkg::cmd_t                    cmd,
	output pbi_pkg::stat_t                        stat,
	output logic                                  out_valid,
	output logic [HANDLE_WIDTH-1:0]               packet_handle_res,
	output logic                                  last
);

	localparam int PTR_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

	logic [pbi_pkg::SIZE_W-1:0]  block_size_q;
	logic [pbi_pkg::ORDER_W-1:0] send_order_q;
	logic [MAX_BLOCK-1:0]        occ_q;
	logic [PTR_W-1:0]            put_q, send_q;
	logic                        out_valid_q;
	logic [HANDLE_WIDTH-1:0]     res_q;
	logic                        last_q;

	logic [pbi_pkg::SIZE_W-1:0]  size_eff;
	logic [pbi_pkg::ENTRY_W-1:0] slot4;
	logic [PTR_W-1:0]            slot_idx, low_idx, rd_addr;
	logic                        slot_in, hit;
	logic [PTR_W:0]              put_inc, send_inc;
	logic [PTR_W-1:0]            put_adv, send_adv;
	logic [HANDLE_WIDTH-1:0]     rd_data;

	assign size_eff = (block_size_q == '0) ? pbi_pkg::SIZE_W'(1) :
		(block_size_q > pbi_pkg::SIZE_W'(MAX_BLOCK)) ? pbi_pkg::SIZE_W'(MAX_BLOCK) :
		block_size_q;

	assign slot4    = send_order_q[{send_q, 2'b00} +: pbi_pkg::ENTRY_W];
	assign slot_idx = slot4[PTR_W-1:0];
	assign slot_in  = ({1'b0, slot4} < size_eff);
	assign hit      = slot_in && occ_q[slot_idx];

	always_comb begin
		low_idx = '0;
		for (int i = MAX_BLOCK - 1; i >= 0; i--) begin
			if (occ_q[i]) begin
				low_idx = PTR_W'(i);
			end
		end
	end

	assign put_inc  = {1'b0, put_q} + (PTR_W+1)'(1);
	assign send_inc = {1'b0, send_q} + (PTR_W+1)'(1);
	assign put_adv  = (pbi_pkg::SIZE_W'(put_inc) >= size_eff) ? '0 : put_inc[PTR_W-1:0];
	assign send_adv = (pbi_pkg::SIZE_W'(send_inc) >= size_eff) ? '0 : send_inc[PTR_W-1:0];

	assign rd_addr = cmd.read_hit ? slot_idx : low_idx;

	pbi_ram #(
		.WIDTH (HANDLE_WIDTH),
		.DEPTH (MAX_BLOCK)
	) u_slots (
		.clk     (clk),
		.wr_en   (cmd.store),
		.wr_addr (put_q),
		.wr_data (packet_handle),
		.rd_en   (cmd.read_hit | cmd.read_flush),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= pbi_pkg::BLOCK_SIZE_RST;
			send_order_q <= pbi_pkg::SEND_ORDER_RST;
			occ_q        <= '0;
			put_q        <= '0;
			send_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					pbi_pkg::REG_BLOCK_SIZE: block_size_q <= cfg_data[pbi_pkg::SIZE_W-1:0];
					pbi_pkg::REG_SEND_ORDER: send_order_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.store) begin
				occ_q[put_q] <= 1'b1;
				put_q        <= put_adv;
			end
			if (cmd.clr_ptrs) begin
				put_q  <= '0;
				send_q <= '0;
			end
			if (cmd.read_hit) begin
				occ_q[slot_idx] <= 1'b0;
				send_q          <= send_adv;
			end
			if (cmd.read_flush) begin
				occ_q[low_idx] <= 1'b0;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_q  <= rd_data;
			last_q <= cmd.last;
		end
	end

	assign stat.hit       = hit;
	assign stat.occ_any   = |occ_q;
	assign stat.out_free  = !out_valid_q || !out_stall;
	assign stat.ptrs_zero = (put_q == '0) && (send_q == '0);

	assign out_valid         = out_valid_q;
	assign packet_handle_res = res_q;
	assign last              = last_q;

endmodule

`default_nettype wire

>>> sv/packet_block_interleaver.sv
// Channel     Signals                               Direction
// in          in_valid, in_stall, mode, packet_handle   request in
// out         out_valid, out_stall, packet_handle_res, last   result out
// cfg         cfg_valid, cfg_ready, cfg_index, cfg_data     register write in
//
// A write request stores its handle and then checks the slot at the send pointer; each
// released handle takes a slot check, then the registered slot RAM read into the output register.
// A flush clears both pointers, then reads out each occupied slot in the same way, lowest first.
// Reset clears occupancy and pointers at once; the slot RAM is never cleared.
// A stalled output holds the sequencer in its load step; the next request is
// taken once the final handle of the current one sits in the output register, or once none is left.
// Top level of the packet block interleaver.
// Depends on pbi_pkg, pbi_ctrl, pbi_datapath and the defines header.
`default_nettype none

`include "packet_block_interleaver_defines.svh"

module packet_block_interleaver #(
	parameter int MAX_BLOCK    = 16,
	parameter int HANDLE_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          mode,
	input  wire logic [HANDLE_WIDTH-1:0]       packet_handle,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [HANDLE_WIDTH-1:0]            packet_handle_res,
	output logic                               last,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [pbi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pbi_pkg::ORDER_W-1:0]   cfg_data
);

	pbi_pkg::cmd_t  cmd;
	pbi_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	pbi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	pbi_datapath #(
		.MAX_BLOCK    (MAX_BLOCK),
		.HANDLE_WIDTH (HANDLE_WIDTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.packet_handle     (packet_handle),
		.out_stall         (out_stall),
		.cmd               (cmd),
		.stat              (stat),
		.out_valid         (out_valid),
		.packet_handle_res (packet_handle_res),
		.last              (last)
	);

	`PBI_ASSERT_NEXT(a_busy_after_req, clk, arst_n, in_valid && !in_stall, in_stall)
	`PBI_ASSERT_IMPL(a_load_when_free, clk, arst_n, cmd.load, !(out_valid && out_stall))
	`PBI_ASSERT_NEXT(a_flush_ptrs, clk, arst_n, in_valid && !in_stall && mode, stat.ptrs_zero)

endmodule

`default_nettype wire
